// ===== rtl/bpps_pkg.sv =====
// Shared types, constants and helper functions of the Blinn-Phong point light shader.
// Depends on nothing; every other file of the block imports it.
package bpps_pkg;

	localparam int POS_WIDTH = 16;
	localparam int NRM_W = 16;
	localparam int Q_FRAC = 14;
	localparam int ONE_Q14 = 16384;
	localparam int DIFF_W = 25;
	localparam int DIFF_LIMIT = 16777215;
	localparam int MAG_W = DIFF_W - 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int ROOT_W = DIFF_W;
	localparam int ISQRT_LAT = ROOT_W;
	localparam int UQ_W = Q_FRAC + 1;
	localparam int NORM_LAT = ISQRT_LAT + UQ_W + 7;
	localparam int CFG_W = 48;
	localparam int COLOR_W = 24;
	localparam int IDX_W = 2;
	localparam int CMP_W = (POS_WIDTH + 1 > DIFF_W) ? POS_WIDTH + 1 : DIFF_W;

	typedef logic signed [DIFF_W-1:0] vcomp_t;
	typedef logic signed [NRM_W-1:0] ucomp_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_LIGHT_POS = 2'd0;
	localparam reg_idx_t REG_CAMERA_POS = 2'd1;
	localparam reg_idx_t REG_LIGHT_COLOR = 2'd2;

	typedef struct packed {
		logic [7:0] base_red;
		logic [7:0] base_green;
		logic [7:0] base_blue;
		logic [7:0] specular_level;
		logic signed [POS_WIDTH-1:0] pos_x;
		logic signed [POS_WIDTH-1:0] pos_y;
		logic signed [POS_WIDTH-1:0] pos_z;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
	} fragment_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pixel_t;

	localparam logic signed [CMP_W-1:0] LIM_HI = CMP_W'(DIFF_LIMIT);
	localparam logic signed [CMP_W-1:0] LIM_LO = -LIM_HI;

	function automatic vcomp_t sat_diff(input logic [CFG_W-1:0] reg_v, input int unsigned idx,
		input logic signed [POS_WIDTH-1:0] pos);
		logic [2*CFG_W-1:0] wide;
		logic signed [POS_WIDTH-1:0] coord;
		logic signed [CMP_W-1:0] d;
		wide = {{CFG_W{1'b0}}, reg_v} >> (idx * POS_WIDTH);
		coord = wide[POS_WIDTH-1:0];
		d = CMP_W'(coord) - CMP_W'(pos);
		if (d > LIM_HI) begin
			return vcomp_t'(LIM_HI);
		end else if (d < LIM_LO) begin
			return vcomp_t'(LIM_LO);
		end
		return vcomp_t'(d);
	endfunction

	function automatic ucomp_t clamp_normal(input logic signed [NRM_W-1:0] n);
		if (n > ucomp_t'(ONE_Q14)) begin
			return ucomp_t'(ONE_Q14);
		end else if (n < -ucomp_t'(ONE_Q14)) begin
			return -ucomp_t'(ONE_Q14);
		end
		return n;
	endfunction

endpackage

// ===== rtl/bpps_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on bpps_pkg for the radicand and root widths.
module bpps_isqrt import bpps_pkg::*; (
	input logic clk,
	input logic [SQ_W-1:0] radicand,
	output logic [ROOT_W-1:0] root
);

	localparam int TW = SQ_W + 2;

	logic [SQ_W-1:0] rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] rt_s [ROOT_W+1];

	assign rem_s[0] = radicand;
	assign rt_s[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam int B = ROOT_W - 1 - j;
		logic [TW-1:0] trial;
		assign trial = (TW'(rt_s[j]) << (B + 1)) + (TW'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (TW'(rem_s[j]) >= trial) begin
				rem_s[j+1] <= rem_s[j] - SQ_W'(trial);
				rt_s[j+1] <= rt_s[j] | (ROOT_W'(1) << B);
			end else begin
				rem_s[j+1] <= rem_s[j];
				rt_s[j+1] <= rt_s[j];
			end
		end
	end

	assign root = rt_s[ROOT_W];

endmodule

// ===== rtl/bpps_norm.sv =====
// Pipelined vector normalizer: scales a three-component vector to Q1.14 unit length.
// Depends on bpps_pkg and instantiates bpps_isqrt.
module bpps_norm import bpps_pkg::*; (
	input logic clk,
	input vcomp_t vec [3],
	output ucomp_t dir [3]
);

	localparam int K_W = $clog2(MAG_W);
	localparam int NUM_W = MAG_W + Q_FRAC;
	localparam int DIV_W = ROOT_W + UQ_W;

	logic [MAG_W-1:0] mag [3];
	logic [MAG_W-1:0] mx;
	vcomp_t c_s1 [3];
	logic [MAG_W-1:0] m_s1;
	logic [K_W-1:0] k;
	vcomp_t c_s2 [3];
	logic [K_W-1:0] k_s2;
	logic zero_s2;
	vcomp_t sc_s3 [3];
	logic zero_s3;
	logic signed [SQ_W-1:0] prod [3];
	logic [SQ_W-3:0] sq_s4 [3];
	vcomp_t sc_s4 [3];
	logic zero_s4;
	logic [SQ_W-1:0] s_s5;
	vcomp_t sc_s5 [3];
	logic zero_s5;
	vcomp_t sc_d [ISQRT_LAT][3];
	logic zero_d [ISQRT_LAT];
	logic [ROOT_W-1:0] len;
	logic [NUM_W-1:0] rem_s [UQ_W+1][3];
	logic [UQ_W-1:0] quo_s [UQ_W+1][3];
	logic neg_s [UQ_W+1][3];
	logic [ROOT_W-1:0] len_s [UQ_W+1];
	logic zero_s [UQ_W+1];
	ucomp_t dir_s47 [3];

	always_comb begin
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = MAG_W'((vec[i] < 0) ? -vec[i] : vec[i]);
			if (mag[i] > mx) begin
				mx = mag[i];
			end
		end
	end

	always_comb begin
		k = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (m_s1[b]) begin
				k = K_W'(MAG_W - 1 - b);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = SQ_W'(sc_s3[i]) * SQ_W'(sc_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= vec;
		m_s1 <= mx;
		c_s2 <= c_s1;
		k_s2 <= k;
		zero_s2 <= (m_s1 == '0);
		for (int i = 0; i < 3; i++) begin
			sc_s3[i] <= vcomp_t'(c_s2[i] <<< k_s2);
			sq_s4[i] <= prod[i][SQ_W-3:0];
		end
		zero_s3 <= zero_s2;
		sc_s4 <= sc_s3;
		zero_s4 <= zero_s3;
		s_s5 <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
		sc_s5 <= sc_s4;
		zero_s5 <= zero_s4;
		sc_d[0] <= sc_s5;
		zero_d[0] <= zero_s5;
		for (int j = 1; j < ISQRT_LAT; j++) begin
			sc_d[j] <= sc_d[j-1];
			zero_d[j] <= zero_d[j-1];
		end
	end

	bpps_isqrt u_isqrt (
		.clk(clk),
		.radicand(s_s5),
		.root(len)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s[0][i] <= sc_d[ISQRT_LAT-1][i] < 0;
			rem_s[0][i] <= NUM_W'(MAG_W'((sc_d[ISQRT_LAT-1][i] < 0) ?
				-sc_d[ISQRT_LAT-1][i] : sc_d[ISQRT_LAT-1][i])) << Q_FRAC;
			quo_s[0][i] <= '0;
		end
		len_s[0] <= len;
		zero_s[0] <= zero_d[ISQRT_LAT-1];
	end

	for (genvar j = 0; j < UQ_W; j++) begin : g_div
		localparam int B = UQ_W - 1 - j;
		logic [DIV_W-1:0] trial;
		assign trial = DIV_W'(len_s[j]) << B;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (DIV_W'(rem_s[j][i]) >= trial) begin
					rem_s[j+1][i] <= rem_s[j][i] - NUM_W'(trial);
					quo_s[j+1][i] <= quo_s[j][i] | (UQ_W'(1) << B);
				end else begin
					rem_s[j+1][i] <= rem_s[j][i];
					quo_s[j+1][i] <= quo_s[j][i];
				end
				neg_s[j+1][i] <= neg_s[j][i];
			end
			len_s[j+1] <= len_s[j];
			zero_s[j+1] <= zero_s[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (zero_s[UQ_W]) begin
				dir_s47[i] <= '0;
			end else if (neg_s[UQ_W][i]) begin
				dir_s47[i] <= -ucomp_t'(quo_s[UQ_W][i]);
			end else begin
				dir_s47[i] <= ucomp_t'(quo_s[UQ_W][i]);
			end
		end
	end

	assign dir = dir_s47;

endmodule

// ===== rtl/blinn_phong_point_light_shade.sv =====
// Top level of the Blinn-Phong point light shader: register file, attenuation and color path.
// Depends on bpps_pkg and instantiates bpps_isqrt and bpps_norm.
//
// Usage: a fragment item is taken at a rising edge where start is high and busy is low.
// busy stays low, so a new item may be taken in every cycle, and the block shades one item
// per clock for as long as items keep coming. The shaded pixel appears on pixel with done
// high for exactly one cycle; items leave in the order they came. The result path runs through
// two vector normalizers in series, each with a 25-stage square root and a 15-stage divider,
// followed by the dot products, five squarings and the color multipliers. The receiver
// cannot stall the block, so it must take every result. Registers are written through wr_en,
// wr_index and wr_data with no wait state; the user must write them only while no item is in
// flight, as the block itself does not enforce it. Reset clears the light and camera positions
// to zero, sets the light color to white and drops every item in flight; no other setup is needed.
module blinn_phong_point_light_shade import bpps_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fragment_t fragment,
	output logic done,
	output pixel_t pixel,
	input logic wr_en,
	input reg_idx_t wr_index,
	input logic [CFG_W-1:0] wr_data
);

	localparam int LAT = 2 * NORM_LAT + 16;
	localparam int SIDE_DLY = 2 * NORM_LAT + 1;
	localparam int LU_DLY = NORM_LAT + 1;
	localparam int ATT_W = 17;
	localparam int ATT_N_W = 42;
	localparam int DC_W = ATT_N_W + 1;
	localparam int ATT_TW = DC_W + ATT_W - 1;
	localparam int D_W = SQ_W + 2;
	localparam int ATT_DLY = (2 * NORM_LAT + 11) - (ISQRT_LAT + ATT_W + 4);
	localparam int PROD_W = 2 * NRM_W;
	localparam int SPEC_STEPS = 5;
	localparam int X1_W = 16 + UQ_W;
	localparam int X2_W = X1_W + ATT_W;
	localparam int NUM_W = 54;
	localparam int DEN_SH = 30;
	localparam int T_W = NUM_W - DEN_SH;
	localparam int TL_W = 20;
	localparam int RC_W = 21;
	localparam int MUL_W = TL_W + RC_W;
	localparam logic [ATT_N_W-1:0] ATT_NUM = ATT_N_W'(64'd1000 << 32);
	localparam logic [DC_W-1:0] DC_CAP = DC_W'(1) << ATT_N_W;
	localparam logic [D_W-1:0] ATT_BASE = D_W'(65536000);
	localparam logic [D_W-1:0] ATT_LIN = D_W'(5120);
	localparam logic [T_W-1:0] SAT_T = T_W'(652800);
	localparam logic [RC_W-1:0] RECIP = RC_W'(1684301);

	typedef struct packed {
		logic [2:0][NRM_W-1:0] nrm;
		logic [2:0][7:0] base;
		logic [7:0] sl;
	} side_t;

	typedef struct packed {
		logic [2:0][7:0] base;
		logic [7:0] sl;
	} col_t;

	function automatic logic [UQ_W-1:0] clamp_dot(input logic signed [PROD_W+1:0] p);
		logic signed [PROD_W+1:0] sh;
		if (p <= 0) begin
			return '0;
		end
		sh = p >>> Q_FRAC;
		if (sh > (PROD_W + 2)'(ONE_Q14)) begin
			return UQ_W'(ONE_Q14);
		end
		return UQ_W'(sh);
	endfunction

	logic [CFG_W-1:0] light_pos_q;
	logic [CFG_W-1:0] camera_pos_q;
	logic [COLOR_W-1:0] light_color_q;
	logic [LAT:1] vld_s;

	logic signed [POS_WIDTH-1:0] pos_in [3];
	logic signed [NRM_W-1:0] nrm_in [3];
	vcomp_t ld_s1 [3];
	vcomp_t cd_s1 [3];
	side_t side_s1;
	logic signed [SQ_W-1:0] ldsq [3];
	logic [SQ_W-3:0] sq_s2 [3];
	logic [SQ_W-1:0] s_s3;
	logic [SQ_W-1:0] s_d [ISQRT_LAT];
	logic [ROOT_W-1:0] q;
	logic [D_W-1:0] dd;
	logic [ATT_N_W-1:0] att_rem_s [ATT_W+1];
	logic [ATT_W-1:0] att_quo_s [ATT_W+1];
	logic [DC_W-1:0] att_dc_s [ATT_W+1];
	logic [ATT_W-1:0] att_d [ATT_DLY];
	ucomp_t lu [3];
	ucomp_t vu [3];
	vcomp_t hs_s49 [3];
	ucomp_t hu [3];
	ucomp_t lu_d [LU_DLY][3];
	side_t side_d [SIDE_DLY];
	logic signed [PROD_W-1:0] pd_s97 [3];
	logic signed [PROD_W-1:0] ph_s97 [3];
	col_t col_s97;
	logic [UQ_W-1:0] diff_s98;
	logic [UQ_W-1:0] spw_s [SPEC_STEPS+1];
	logic [UQ_W-1:0] dfs_s [SPEC_STEPS+1];
	col_t col_s [SPEC_STEPS+1];
	logic [15:0] bl_s104 [3];
	logic [15:0] lg_s104 [3];
	logic [UQ_W-1:0] diff_s104;
	logic [UQ_W-1:0] spec_s104;
	logic [2:0][7:0] base_s104;
	logic [X1_W-1:0] x1_s105 [3];
	logic [X1_W-1:0] y1_s105 [3];
	logic [2:0][7:0] base_s105;
	logic [X2_W-1:0] x2_s106 [3];
	logic [X2_W-1:0] y2_s106 [3];
	logic [2:0][7:0] base_s106;
	logic [NUM_W-1:0] num_s107 [3];
	logic [T_W-1:0] t [3];
	logic [TL_W-1:0] tl_s108 [3];
	logic sat_s108 [3];
	logic [MUL_W-1:0] rprod [3];
	logic [7:0] v_s109 [3];
	logic sat_s109 [3];
	pixel_t pix_s110;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_pos_q <= '0;
			camera_pos_q <= '0;
			light_color_q <= '1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LIGHT_POS: light_pos_q <= wr_data;
				REG_CAMERA_POS: camera_pos_q <= wr_data;
				REG_LIGHT_COLOR: light_color_q <= wr_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], start & ~busy};
		end
	end

	assign pos_in[0] = fragment.pos_x;
	assign pos_in[1] = fragment.pos_y;
	assign pos_in[2] = fragment.pos_z;
	assign nrm_in[0] = fragment.normal_x;
	assign nrm_in[1] = fragment.normal_y;
	assign nrm_in[2] = fragment.normal_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ld_s1[i] <= sat_diff(light_pos_q, i, pos_in[i]);
			cd_s1[i] <= sat_diff(camera_pos_q, i, pos_in[i]);
			side_s1.nrm[i] <= clamp_normal(nrm_in[i]);
		end
		side_s1.base[0] <= fragment.base_red;
		side_s1.base[1] <= fragment.base_green;
		side_s1.base[2] <= fragment.base_blue;
		side_s1.sl <= fragment.specular_level;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ldsq[i] = SQ_W'(ld_s1[i]) * SQ_W'(ld_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= ldsq[i][SQ_W-3:0];
		end
		s_s3 <= SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);
		s_d[0] <= s_s3;
		for (int j = 1; j < ISQRT_LAT; j++) begin
			s_d[j] <= s_d[j-1];
		end
	end

	bpps_isqrt u_att_sqrt (
		.clk(clk),
		.radicand(s_s3),
		.root(q)
	);

	assign dd = ATT_BASE + D_W'(q) * ATT_LIN + {s_d[ISQRT_LAT-1], 1'b0};

	always_ff @(posedge clk) begin
		att_rem_s[0] <= ATT_NUM;
		att_quo_s[0] <= '0;
		att_dc_s[0] <= (dd >= D_W'(DC_CAP)) ? DC_CAP : dd[DC_W-1:0];
	end

	for (genvar j = 0; j < ATT_W; j++) begin : g_att
		localparam int B = ATT_W - 1 - j;
		logic [ATT_TW-1:0] trial;
		assign trial = ATT_TW'(att_dc_s[j]) << B;
		always_ff @(posedge clk) begin
			if (ATT_TW'(att_rem_s[j]) >= trial) begin
				att_rem_s[j+1] <= att_rem_s[j] - ATT_N_W'(trial);
				att_quo_s[j+1] <= att_quo_s[j] | (ATT_W'(1) << B);
			end else begin
				att_rem_s[j+1] <= att_rem_s[j];
				att_quo_s[j+1] <= att_quo_s[j];
			end
			att_dc_s[j+1] <= att_dc_s[j];
		end
	end

	always_ff @(posedge clk) begin
		att_d[0] <= att_quo_s[ATT_W];
		for (int j = 1; j < ATT_DLY; j++) begin
			att_d[j] <= att_d[j-1];
		end
	end

	bpps_norm u_norm_light (
		.clk(clk),
		.vec(ld_s1),
		.dir(lu)
	);

	bpps_norm u_norm_view (
		.clk(clk),
		.vec(cd_s1),
		.dir(vu)
	);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hs_s49[i] <= vcomp_t'(lu[i]) + vcomp_t'(vu[i]);
		end
	end

	bpps_norm u_norm_half (
		.clk(clk),
		.vec(hs_s49),
		.dir(hu)
	);

	always_ff @(posedge clk) begin
		lu_d[0] <= lu;
		for (int j = 1; j < LU_DLY; j++) begin
			lu_d[j] <= lu_d[j-1];
		end
		side_d[0] <= side_s1;
		for (int j = 1; j < SIDE_DLY; j++) begin
			side_d[j] <= side_d[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pd_s97[i] <= PROD_W'($signed(side_d[SIDE_DLY-1].nrm[i])) * PROD_W'(lu_d[LU_DLY-1][i]);
			ph_s97[i] <= PROD_W'($signed(side_d[SIDE_DLY-1].nrm[i])) * PROD_W'(hu[i]);
		end
		col_s97.base <= side_d[SIDE_DLY-1].base;
		col_s97.sl <= side_d[SIDE_DLY-1].sl;
		diff_s98 <= clamp_dot((PROD_W + 2)'(pd_s97[0]) + (PROD_W + 2)'(pd_s97[1])
			+ (PROD_W + 2)'(pd_s97[2]));
		spw_s[0] <= clamp_dot((PROD_W + 2)'(ph_s97[0]) + (PROD_W + 2)'(ph_s97[1])
			+ (PROD_W + 2)'(ph_s97[2]));
		col_s[0] <= col_s97;
	end

	assign dfs_s[0] = diff_s98;

	for (genvar j = 0; j < SPEC_STEPS; j++) begin : g_spec
		logic [2*UQ_W-1:0] sqr;
		assign sqr = (2 * UQ_W)'(spw_s[j]) * (2 * UQ_W)'(spw_s[j]);
		always_ff @(posedge clk) begin
			spw_s[j+1] <= UQ_W'(sqr >> Q_FRAC);
			dfs_s[j+1] <= dfs_s[j];
			col_s[j+1] <= col_s[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			bl_s104[i] <= 16'(col_s[SPEC_STEPS].base[i]) * 16'(light_color_q[8*i +: 8]);
			lg_s104[i] <= 16'(light_color_q[8*i +: 8]) * 16'(col_s[SPEC_STEPS].sl);
			x1_s105[i] <= X1_W'(bl_s104[i]) * X1_W'(diff_s104);
			y1_s105[i] <= X1_W'(lg_s104[i]) * X1_W'(spec_s104);
			x2_s106[i] <= X2_W'(x1_s105[i]) * X2_W'(att_d[ATT_DLY-1]);
			y2_s106[i] <= X2_W'(y1_s105[i]) * X2_W'(att_d[ATT_DLY-1]);
			num_s107[i] <= ((NUM_W'(base_s106[i]) * NUM_W'(255)) << DEN_SH)
				+ NUM_W'(x2_s106[i]) * NUM_W'(10) + NUM_W'(y2_s106[i]) * NUM_W'(9);
		end
		diff_s104 <= dfs_s[SPEC_STEPS];
		spec_s104 <= spw_s[SPEC_STEPS];
		base_s104 <= col_s[SPEC_STEPS].base;
		base_s105 <= base_s104;
		base_s106 <= base_s105;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i] = num_s107[i][NUM_W-1:DEN_SH];
			rprod[i] = MUL_W'(tl_s108[i]) * MUL_W'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sat_s108[i] <= t[i] >= SAT_T;
			tl_s108[i] <= t[i][TL_W-1:0];
			sat_s109[i] <= sat_s108[i];
			v_s109[i] <= rprod[i][39:32];
		end
		pix_s110.out_red <= sat_s109[0] ? 8'hFF : v_s109[0];
		pix_s110.out_green <= sat_s109[1] ? 8'hFF : v_s109[1];
		pix_s110.out_blue <= sat_s109[2] ? 8'hFF : v_s109[2];
	end

	assign pixel = pix_s110;
	assign done = vld_s[LAT];

endmodule
